>>> sv/sf7t_pkg.sv
// ----------------------------------------------------------------------------
// sf7t_pkg
// Types, constants and lookup functions of the SF7 terminal byte transcoder.
// ----------------------------------------------------------------------------
package sf7t_pkg;

  localparam logic [7:0] BYTE_BELL  = 8'h07;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;
  localparam logic [7:0] UTF8_LEAD  = 8'hC3;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHARSET = 2'd0,
    REG_BELL    = 2'd1,
    REG_SPECIAL = 2'd2,
    REG_ROT13   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CS_NONE = 3'd0,
    CS_UTF8 = 3'd1,
    CS_IBM  = 3'd2,
    CS_ISO  = 3'd3,
    CS_MAC  = 3'd4
  } charset_e;

  typedef enum logic [2:0] {
    SW_RBRACE = 3'd0,
    SW_LBRACE = 3'd1,
    SW_PIPE   = 3'd2,
    SW_RBRK   = 3'd3,
    SW_LBRK   = 3'd4,
    SW_BSLASH = 3'd5,
    SW_NONE   = 3'd6
  } sw_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_start;
    logic       translate;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] charset_mode;
    logic       bell_enable;
    logic       special_mode;
    logic       rot13_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       do_map;
    sw_idx_e    idx;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_ctl_t;

  function automatic sw_idx_e swedish_index(logic [7:0] b);
    case (b)
      8'h7D:   swedish_index = SW_RBRACE;
      8'h7B:   swedish_index = SW_LBRACE;
      8'h7C:   swedish_index = SW_PIPE;
      8'h5D:   swedish_index = SW_RBRK;
      8'h5B:   swedish_index = SW_LBRK;
      8'h5C:   swedish_index = SW_BSLASH;
      default: swedish_index = SW_NONE;
    endcase
  endfunction

  function automatic logic [7:0] utf8_second(sw_idx_e k);
    case (k)
      SW_RBRACE: utf8_second = 8'hA5;
      SW_LBRACE: utf8_second = 8'hA4;
      SW_PIPE:   utf8_second = 8'hB6;
      SW_RBRK:   utf8_second = 8'h85;
      SW_LBRK:   utf8_second = 8'h84;
      SW_BSLASH: utf8_second = 8'h96;
      default:   utf8_second = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] single_map(logic [2:0] cs, sw_idx_e k, logic [7:0] b);
    single_map = b;
    case (cs)
      CS_IBM: begin
        case (k)
          SW_RBRACE: single_map = 8'd134;
          SW_LBRACE: single_map = 8'd132;
          SW_PIPE:   single_map = 8'd148;
          SW_RBRK:   single_map = 8'd143;
          SW_LBRK:   single_map = 8'd142;
          SW_BSLASH: single_map = 8'd153;
          default:   single_map = b;
        endcase
      end
      CS_ISO: begin
        case (k)
          SW_RBRACE: single_map = 8'd229;
          SW_LBRACE: single_map = 8'd228;
          SW_PIPE:   single_map = 8'd246;
          SW_RBRK:   single_map = 8'd197;
          SW_LBRK:   single_map = 8'd196;
          SW_BSLASH: single_map = 8'd214;
          default:   single_map = b;
        endcase
      end
      CS_MAC: begin
        case (k)
          SW_RBRACE: single_map = 8'd140;
          SW_LBRACE: single_map = 8'd138;
          SW_PIPE:   single_map = 8'd154;
          SW_RBRK:   single_map = 8'd129;
          SW_LBRK:   single_map = 8'd128;
          SW_BSLASH: single_map = 8'd133;
          default:   single_map = b;
        endcase
      end
      default: single_map = b;
    endcase
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    is_letter = (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic [7:0] rot13(logic [7:0] b);
    rot13 = b;
    if ((b inside {[8'h41:8'h4D]}) || (b inside {[8'h61:8'h6D]})) begin
      rot13 = b + 8'd13;
    end else if ((b inside {[8'h4E:8'h5A]}) || (b inside {[8'h6E:8'h7A]})) begin
      rot13 = b - 8'd13;
    end
  endfunction

endpackage

>>> sv/sf7_terminal_byte_transcoder.sv
// ----------------------------------------------------------------------------
// sf7_terminal_byte_transcoder
// An accepted item passes from front to queue and from queue to the output
// register. Throughput: one item per cycle while out_ready_i is not held low,
// set by the combinational front classify and back map around a 2-entry queue.
// Reset clears the ANSI state, the queue, the output valid and all config
// registers; no clearing pass.
// ----------------------------------------------------------------------------
module sf7_terminal_byte_transcoder import sf7t_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            in_item_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output out_item_t           out_item_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  cfg_t      cfg_q;
  cls_item_t push_item;
  cls_item_t head;
  q_ctl_t    q_ctl;
  logic      push;
  logic      pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHARSET: cfg_q.charset_mode <= cfg_data_i;
        REG_BELL:    cfg_q.bell_enable  <= cfg_data_i[0];
        REG_SPECIAL: cfg_q.special_mode <= cfg_data_i[0];
        REG_ROT13:   cfg_q.rot13_enable <= cfg_data_i[0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  sf7t_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_ctl.full),
    .q_push_o   (push),
    .q_item_o   (push_item)
  );

  sf7t_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .ctl_o       (q_ctl)
  );

  sf7t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_empty_i   (q_ctl.empty),
    .q_pop_o     (pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

>>> sv/sf7t_front.sv
// ----------------------------------------------------------------------------
// sf7t_front
// Accepts input items, drops muted bells, tracks ANSI CSI state and
// classifies each byte for the back end.
// ----------------------------------------------------------------------------
module sf7t_front import sf7t_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_item_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      q_full_i,
  output logic      q_push_o,
  output cls_item_t q_item_o
);

  logic    ansi_q, ansi_d;
  logic    esc_q, esc_d;
  logic    accept;
  logic    drop;
  logic    ansi_cur, esc_cur;
  sw_idx_e idx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ansi_cur = in_item_i.string_start ? 1'b0 : ansi_q;
    esc_cur  = in_item_i.string_start ? 1'b0 : esc_q;
    drop     = (in_item_i.in_byte == BYTE_BELL) && !cfg_i.bell_enable && !cfg_i.special_mode;
    ansi_d   = ansi_cur;
    esc_d    = 1'b0;
    if (!drop) begin
      if (esc_cur && (in_item_i.in_byte == BYTE_LBRK)) begin
        ansi_d = 1'b1;
      end else if (ansi_cur && is_letter(in_item_i.in_byte)) begin
        ansi_d = 1'b0;
      end
      esc_d = (in_item_i.in_byte == BYTE_ESC);
    end
    idx = swedish_index(in_item_i.in_byte);
  end

  assign q_push_o        = accept && !drop;
  assign q_item_o.data   = in_item_i.in_byte;
  assign q_item_o.idx    = idx;
  assign q_item_o.do_map = in_item_i.translate && !ansi_d && (idx != SW_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ansi_q <= 1'b0;
      esc_q  <= 1'b0;
    end else if (accept) begin
      ansi_q <= ansi_d;
      esc_q  <= esc_d;
    end
  end

endmodule

>>> sv/sf7t_queue.sv
// ----------------------------------------------------------------------------
// sf7t_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module sf7t_queue import sf7t_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_item_i,
  input  logic      pop_i,
  output cls_item_t head_o,
  output q_ctl_t    ctl_o
);

  cls_item_t  mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ctl_o.full  = (cnt_q == 2'd2);
  assign ctl_o.empty = (cnt_q == 2'd0);
  assign do_push     = push_i && !ctl_o.full;
  assign do_pop      = pop_i && !ctl_o.empty;
  assign head_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/sf7t_back.sv
// ----------------------------------------------------------------------------
// sf7t_back
// Maps classified items to output bytes (charset, CR LF, ROT13) and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module sf7t_back import sf7t_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cls_item_t head_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output out_item_t out_item_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  logic      valid_q, valid_d;
  out_item_t res_q, res_d;
  logic      load;
  logic [7:0] b0, b1;
  logic [1:0] cnt;

  assign load    = !q_empty_i && (!valid_q || out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    b0  = head_i.data;
    b1  = 8'h00;
    cnt = 2'd1;
    if (head_i.do_map) begin
      if (cfg_i.charset_mode == CS_UTF8) begin
        b0  = UTF8_LEAD;
        b1  = utf8_second(head_i.idx);
        cnt = 2'd2;
      end else begin
        b0 = single_map(cfg_i.charset_mode, head_i.idx, head_i.data);
      end
    end
    if ((cnt == 2'd1) && (b0 == BYTE_LF)) begin
      b0  = BYTE_CR;
      b1  = BYTE_LF;
      cnt = 2'd2;
    end
    if (cfg_i.rot13_enable) begin
      b0 = rot13(b0);
      b1 = rot13(b1);
    end
    res_d.first_byte  = b0;
    res_d.second_byte = b1;
    res_d.byte_count  = cnt;
    valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the SF7 terminal byte transcoder. A driver feeds text items
// from a pending queue over valid/ready. Each accepted item is run through a
// local transcoder model, which tracks the ANSI CSI and escape state and
// applies bell filtering, the Swedish glyph mapping, newline expansion and
// ROT13. Its results are queued, and the monitor compares them with the
// block's output. Both sides idle at random, and the receiver holds off once
// for a long stretch. A short directed string runs first. Random strings
// follow under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import sf7t_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [47:0] SF7_GLYPHS = {8'h7D, 8'h7B, 8'h7C, 8'h5D, 8'h5B, 8'h5C};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_CHARSET;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  in_item_t            in_item_i   = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  out_item_t           out_item_o;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;

  in_item_t  text_queue[$];
  out_item_t awaited_bytes[$];
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  int        hold_left    = 0;
  logic      hold_done    = 1'b0;
  logic      hold_req     = 1'b0;
  logic      calm         = 1'b0;
  logic      new_string   = 1'b1;
  logic      str_translate = 1'b1;

  logic [2:0] cfg_charset = CS_NONE;
  logic       cfg_bell    = 1'b0;
  logic       cfg_special = 1'b0;
  logic       cfg_rot13   = 1'b0;
  logic       in_csi      = 1'b0;
  logic       esc_seen    = 1'b0;

  sf7_terminal_byte_transcoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic sw_idx_e glyph_slot(logic [7:0] b);
    case (b)
      8'h7D:   return SW_RBRACE;
      8'h7B:   return SW_LBRACE;
      8'h7C:   return SW_PIPE;
      8'h5D:   return SW_RBRK;
      8'h5B:   return SW_LBRK;
      8'h5C:   return SW_BSLASH;
      default: return SW_NONE;
    endcase
  endfunction

  // UTF-8 gives the trailing byte; the other charsets give the single byte.
  function automatic logic [7:0] glyph_code(logic [2:0] cs, sw_idx_e k);
    case (cs)
      CS_UTF8: begin
        case (k)
          SW_RBRACE: return 8'hA5;
          SW_LBRACE: return 8'hA4;
          SW_PIPE:   return 8'hB6;
          SW_RBRK:   return 8'h85;
          SW_LBRK:   return 8'h84;
          default:   return 8'h96;
        endcase
      end
      CS_IBM: begin
        case (k)
          SW_RBRACE: return 8'd134;
          SW_LBRACE: return 8'd132;
          SW_PIPE:   return 8'd148;
          SW_RBRK:   return 8'd143;
          SW_LBRK:   return 8'd142;
          default:   return 8'd153;
        endcase
      end
      CS_ISO: begin
        case (k)
          SW_RBRACE: return 8'd229;
          SW_LBRACE: return 8'd228;
          SW_PIPE:   return 8'd246;
          SW_RBRK:   return 8'd197;
          SW_LBRK:   return 8'd196;
          default:   return 8'd214;
        endcase
      end
      default: begin
        case (k)
          SW_RBRACE: return 8'd140;
          SW_LBRACE: return 8'd138;
          SW_PIPE:   return 8'd154;
          SW_RBRK:   return 8'd129;
          SW_LBRK:   return 8'd128;
          default:   return 8'd133;
        endcase
      end
    endcase
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] rotate13(logic [7:0] b);
    int v;
    v = b;
    if (v >= 65 && v <= 90) return 8'(65 + (v - 65 + 13) % 26);
    if (v >= 97 && v <= 122) return 8'(97 + (v - 97 + 13) % 26);
    return b;
  endfunction

  // Return 1 when the item yields a result; update the escape and CSI state.
  function automatic logic transcode(input in_item_t it, output out_item_t res);
    logic [7:0] c;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
    sw_idx_e    k;
    c   = it.in_byte;
    b1  = 8'h00;
    n   = 2'd1;
    res = '0;
    if (it.string_start) begin
      in_csi   = 1'b0;
      esc_seen = 1'b0;
    end
    if (c == BYTE_BELL && !cfg_bell && !cfg_special) begin
      esc_seen = 1'b0;
      return 1'b0;
    end
    if (esc_seen && c == BYTE_LBRK) begin
      in_csi = 1'b1;
    end else if (in_csi && is_alpha(c)) begin
      in_csi = 1'b0;
    end
    esc_seen = (c == BYTE_ESC);
    b0 = c;
    k  = glyph_slot(c);
    if (it.translate && !in_csi && k != SW_NONE) begin
      case (cfg_charset)
        CS_UTF8: begin
          b0 = UTF8_LEAD;
          b1 = glyph_code(cfg_charset, k);
          n  = 2'd2;
        end
        CS_IBM, CS_ISO, CS_MAC: b0 = glyph_code(cfg_charset, k);
        default: ;
      endcase
    end
    if (n == 2'd1 && b0 == BYTE_LF) begin
      b0 = BYTE_CR;
      b1 = BYTE_LF;
      n  = 2'd2;
    end
    if (cfg_rot13) begin
      b0 = rotate13(b0);
      b1 = rotate13(b1);
    end
    res.first_byte  = b0;
    res.second_byte = b1;
    res.byte_count  = n;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t predicted;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (transcode(in_item_i, predicted)) awaited_bytes.push_back(predicted);
      end
      if (!in_valid_i || in_ready_o) begin
        if (text_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          in_item_i  <= text_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_bytes.size() == 0) begin
          $display("%0t: unexpected result %02h %02h count %0d", $time,
                   out_item_o.first_byte, out_item_o.second_byte, out_item_o.byte_count);
          mismatches++;
        end else begin
          want = awaited_bytes.pop_front();
          if (out_item_o.first_byte !== want.first_byte) begin
            $display("%0t: first_byte expected %02h got %02h", $time,
                     want.first_byte, out_item_o.first_byte);
            mismatches++;
          end
          if (out_item_o.second_byte !== want.second_byte) begin
            $display("%0t: second_byte expected %02h got %02h", $time,
                     want.second_byte, out_item_o.second_byte);
            mismatches++;
          end
          if (out_item_o.byte_count !== want.byte_count) begin
            $display("%0t: byte_count expected %0d got %0d", $time,
                     want.byte_count, out_item_o.byte_count);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(0, 99) >= 28;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("sf7_terminal_byte_transcoder test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_regs(input logic [2:0] cs, input logic bell, input logic spec,
                          input logic rot);
    for (int r = 0; r < 4; r++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(r);
      case (cfg_reg_e'(r))
        REG_CHARSET: begin
          cfg_data_i  <= cs;
          cfg_charset =  cs;
        end
        REG_BELL: begin
          cfg_data_i <= {2'b00, bell};
          cfg_bell   =  bell;
        end
        REG_SPECIAL: begin
          cfg_data_i  <= {2'b00, spec};
          cfg_special =  spec;
        end
        default: begin
          cfg_data_i <= {2'b00, rot};
          cfg_rot13  =  rot;
        end
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(input logic [7:0] b, input logic start, input logic xl);
    in_item_t it;
    it.in_byte      = b;
    it.string_start = start;
    it.translate    = xl;
    text_queue.push_back(it);
  endtask

  task automatic put_byte(input logic [7:0] b);
    push_item(b, new_string || $urandom_range(0, 99) < 3, str_translate);
    new_string = 1'b0;
  endtask

  // Mostly well-formed strings: text, glyphs, CSI sequences; some noise.
  task automatic fill_text(input int n);
    int pick;
    int k;
    new_string    = 1'b1;
    str_translate = $urandom_range(0, 3) != 0;
    while (text_queue.size() < n) begin
      if ($urandom_range(0, 11) == 0) begin
        new_string    = 1'b1;
        str_translate = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        put_byte(8'($urandom_range(32, 126)));
      end else if (pick < 48) begin
        k = $urandom_range(0, 5);
        put_byte(SF7_GLYPHS[8*k +: 8]);
      end else if (pick < 64) begin
        put_byte(BYTE_ESC);
        if ($urandom_range(0, 9) == 0) put_byte(BYTE_BELL);
        put_byte(BYTE_LBRK);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 4) == 0) put_byte(8'h3B);
          else put_byte(8'($urandom_range(48, 57)));
        end
        if ($urandom_range(0, 7) != 0) begin
          k = $urandom_range(0, 51);
          put_byte(8'(k < 26 ? 65 + k : 97 + k - 26));
        end
      end else if (pick < 72) begin
        put_byte(BYTE_LF);
      end else if (pick < 80) begin
        put_byte(BYTE_BELL);
      end else if (pick < 85) begin
        put_byte(BYTE_ESC);
      end else begin
        put_byte(8'($urandom_range(1, 255)));
      end
    end
  endtask

  task automatic settle();
    while (text_queue.size() != 0 || in_valid_i || awaited_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_regs(CS_UTF8, 1'b0, 1'b0, 1'b0);
    push_item(8'h41, 1'b1, 1'b1);
    push_item(8'h7D, 1'b0, 1'b1);
    push_item(8'h7B, 1'b0, 1'b1);
    push_item(8'h7C, 1'b0, 1'b1);
    push_item(8'h5D, 1'b0, 1'b1);
    push_item(8'h5B, 1'b0, 1'b1);
    push_item(8'h5C, 1'b0, 1'b1);
    push_item(8'h7D, 1'b1, 1'b0);
    push_item(BYTE_LF, 1'b0, 1'b0);
    push_item(BYTE_ESC, 1'b1, 1'b1);
    push_item(BYTE_LBRK, 1'b0, 1'b1);
    push_item(8'h7D, 1'b0, 1'b1);
    push_item(8'h33, 1'b0, 1'b1);
    push_item(8'h6D, 1'b0, 1'b1);
    push_item(8'h7B, 1'b0, 1'b1);
    push_item(BYTE_ESC, 1'b0, 1'b1);
    push_item(BYTE_BELL, 1'b0, 1'b1);
    push_item(BYTE_LBRK, 1'b0, 1'b1);
    push_item(BYTE_ESC, 1'b0, 1'b1);
    push_item(BYTE_LBRK, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'h01, 1'b0, 1'b1);
    push_item(BYTE_LF, 1'b0, 1'b1);
    push_item(8'h7A, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       set_regs(CS_NONE, 1'b0, 1'b0, 1'b0);
        1:       set_regs(CS_UTF8, 1'b0, 1'b0, 1'b0);
        2:       set_regs(CS_IBM,  1'b1, 1'b0, 1'b0);
        3:       set_regs(CS_ISO,  1'b0, 1'b1, 1'b1);
        4:       set_regs(CS_MAC,  1'b1, 1'b1, 1'b0);
        5:       set_regs(3'd7,    1'b0, 1'b0, 1'b1);
        6:       set_regs(3'd5,    1'b1, 1'b0, 1'b1);
        7:       set_regs(CS_UTF8, 1'b0, 1'b1, 1'b1);
        8:       set_regs(CS_MAC,  1'b0, 1'b0, 1'b1);
        default: set_regs(3'd6,    1'b1, 1'b1, 1'b1);
      endcase
      calm     = (p == 3);
      hold_req = (p == 5);
      fill_text(40);
      settle();
    end

    if (awaited_bytes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_bytes.size());
    end
    if (mismatches == 0 && awaited_bytes.size() == 0) begin
      $display("sf7_terminal_byte_transcoder test passed");
    end else begin
      $display("sf7_terminal_byte_transcoder test failed");
    end
    $finish;
  end

endmodule
